[design/ntc_pkg.sv]
// ----------------------------------------------------------------------------
// ntc_pkg: shared types and constants of the NTC thermistor temperature block
// Widths, codes, table of logarithm steps and the command and flag structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ntc_pkg;

    // Sample window
    localparam int SAMPLE_W   = 12;
    localparam int WINDOW     = 10;
    localparam int SLOT_W     = 4;
    localparam int SUM_W      = 16;
    // floor(sum / 10) == (sum * 52429) >> 19 for every sum below 2^18
    localparam int MEAN_RECIP = 52429;
    localparam int MEAN_SHIFT = 19;
    localparam int MEAN_PW    = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int RES_W      = 20;
    localparam int BETA_W     = 14;
    localparam int T0_W       = 16;
    localparam int MV_W       = 13;
    localparam int CODE_W     = 12;

    localparam logic [RES_W-1:0]  RST_SERIES  = 20'd10000;
    localparam logic [RES_W-1:0]  RST_NOMR    = 20'd10000;
    localparam logic [BETA_W-1:0] RST_BETA    = 14'd3950;
    localparam logic [T0_W-1:0]   RST_T0      = 16'd29815;
    localparam logic [MV_W-1:0]   RST_REF     = 13'd3300;
    localparam logic [MV_W-1:0]   RST_FS_MV   = 13'd3300;
    localparam logic [CODE_W-1:0] RST_FS_CODE = 12'd4095;

    // Datapath widths
    localparam int NUM_W    = 25;
    localparam int DEN100_W = 19;
    localparam int RN0_W    = 33;
    localparam int RN1_W    = 32;
    localparam int RN_W     = 45;
    localparam int RLO_W    = 32;
    localparam int RHI_W    = 43;
    localparam int LN_ARG_W = 48;
    localparam int LN_CNT_W = 6;
    localparam int LN_M_W   = 32;
    localparam int LN_ACC_W = 17;
    localparam int LN_K_W   = 22;
    localparam int LN_STEPS = 16;
    localparam int LN_J_W   = 4;
    localparam int LQ_W     = 24;
    localparam int TB_W     = 30;
    localparam int TB100_W  = 37;
    localparam int B100_W   = 21;
    localparam int TL_W     = 41;
    localparam int TDEN_W   = 42;
    localparam int NUMER_W  = 53;
    localparam int DIVD_W   = 54;
    localparam int DIVS_W   = 41;
    localparam int DIV_CNT_W = 6;
    localparam int TEMP_W   = 14;
    localparam int STATUS_W = 3;

    // Q16 constants of the logarithm
    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam logic [15:0] LN_TAB [LN_STEPS] = '{
        16'd26573, 16'd14624, 16'd7719, 16'd3973, 16'd2017, 16'd1016, 16'd510, 16'd256,
        16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2,   16'd1
    };

    // Temperatures in centikelvin and centidegrees
    localparam logic [15:0] CK_OFFSET = 16'd27315;
    localparam int          Q_FLOOR   = 26315;
    localparam int          Q_CEIL    = 35315;
    localparam logic [TEMP_W-1:0] TEMP_DEFAULT   = 14'd2500;
    localparam logic [TEMP_W-1:0] TEMP_FLOOR_SUB = 14'd2000;
    localparam logic [TEMP_W-1:0] TEMP_CEIL_SUB  = 14'd4000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERIES,
        CFG_NOMINAL_R,
        CFG_BETA,
        CFG_T0,
        CFG_REF,
        CFG_FS_MV,
        CFG_FS_CODE
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL,
        ST_ZERO_MEAN,
        ST_VOLT_LOW,
        ST_R_RANGE,
        ST_BELOW,
        ST_ABOVE
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MEAN,
        OP_VOLT,
        OP_CLIP,
        OP_DIFF,
        OP_RN0,
        OP_RN1,
        OP_RCMP,
        OP_LN_START,
        OP_LQ_UPD,
        OP_TB,
        OP_TL,
        OP_TDEN,
        OP_DIV_START,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        LN_SEL_RN,
        LN_SEL_RD,
        LN_SEL_NOM
    } t_ln_sel;

    typedef struct packed {
        t_op     op;
        t_status status;
        t_ln_sel ln_sel;
    } t_cmd;

    typedef struct packed {
        logic zero_mean;
        logic lim_low;
        logic volt_low;
        logic r_out;
        logic ln_done;
        logic tden_zero;
        logic tden_neg;
        logic div_done;
        logic q_low;
        logic q_high;
    } t_flags;

endpackage

[design/ntc_ln.sv]
// ----------------------------------------------------------------------------
// ntc_ln: natural logarithm in Q16
// Normalizes the argument to Q30, then runs sixteen multiplicative steps and
// returns (k+1)*ln2 minus the sum of the taken table entries.
// ----------------------------------------------------------------------------
module ntc_ln (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ntc_pkg::LN_ARG_W-1:0]     i_arg,
    output logic                             o_done,
    output logic signed [ntc_pkg::LQ_W-1:0]  o_res
);
    import ntc_pkg::*;

    typedef enum logic [1:0] {L_IDLE, L_NORM, L_ITER, L_FIN} t_lstate;

    t_lstate                 r_state;
    logic [LN_ARG_W-1:0]     r_x;
    logic [LN_CNT_W-1:0]     r_cnt;
    logic [LN_M_W-1:0]       r_m;
    logic [LN_J_W-1:0]       r_j;
    logic [LN_ACC_W-1:0]     r_acc;
    logic                    r_done;
    logic signed [LQ_W-1:0]  r_res;

    logic [LN_M_W-1:0]       w_t;
    logic [4:0]              w_shift;
    logic [LN_CNT_W-1:0]     w_kp1;
    logic [LN_K_W-1:0]       w_kterm;

    assign w_shift = {1'b0, r_j} + 5'd1;
    assign w_t     = r_m + (r_m >> w_shift);
    // The top set bit sits at 47 - count, so k + 1 is 48 - count.
    assign w_kp1   = LN_CNT_W'(LN_ARG_W) - r_cnt;
    assign w_kterm = LN_K_W'(w_kp1) * LN_K_W'(LN2_Q16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_x     <= (i_arg == '0) ? LN_ARG_W'(1) : i_arg;
                        r_cnt   <= '0;
                        r_state <= L_NORM;
                    end
                end
                L_NORM: begin
                    if (r_x[LN_ARG_W-1]) begin
                        r_m     <= {1'b0, r_x[LN_ARG_W-1 -: LN_M_W-1]};
                        r_j     <= '0;
                        r_acc   <= '0;
                        r_state <= L_ITER;
                    end else if (r_x[LN_ARG_W-1 -: 8] == 8'd0) begin
                        r_x   <= r_x << 8;
                        r_cnt <= r_cnt + LN_CNT_W'(8);
                    end else begin
                        r_x   <= r_x << 1;
                        r_cnt <= r_cnt + LN_CNT_W'(1);
                    end
                end
                L_ITER: begin
                    if (!w_t[LN_M_W-1]) begin
                        r_m   <= w_t;
                        r_acc <= r_acc + LN_ACC_W'(LN_TAB[r_j]);
                    end
                    if (r_j == LN_J_W'(LN_STEPS - 1)) begin
                        r_state <= L_FIN;
                    end
                    r_j <= r_j + 1'b1;
                end
                L_FIN: begin
                    r_res   <= $signed(LQ_W'(w_kterm)) - $signed(LQ_W'(r_acc));
                    r_done  <= 1'b1;
                    r_state <= L_IDLE;
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[design/ntc_div.sv]
// ----------------------------------------------------------------------------
// ntc_div: restoring divider
// One quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module ntc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ntc_pkg::DIVD_W-1:0]    i_dividend,
    input  logic [ntc_pkg::DIVS_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [ntc_pkg::DIVD_W-1:0]    o_quot
);
    import ntc_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVS_W:0]       r_rem;
    logic [DIVD_W-1:0]     r_q;
    logic [DIVS_W-1:0]     r_d;

    logic [DIVS_W:0]       w_sh;
    logic                  w_ge;

    assign w_sh = {r_rem[DIVS_W-1:0], r_q[DIVD_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem <= w_ge ? (w_sh - {1'b0, r_d}) : w_sh;
                r_q   <= {r_q[DIVD_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[design/ntc_dp.sv]
// ----------------------------------------------------------------------------
// ntc_dp: datapath of the NTC thermistor temperature block
// Sample ring with running sum, configuration registers, divider and beta
// equation arithmetic, log and division units, and the result register.
// ----------------------------------------------------------------------------
module ntc_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ntc_pkg::t_cmd                      i_cmd,
    input  logic [ntc_pkg::SAMPLE_W-1:0]       i_adc_sample,
    input  logic                               i_cfg_we,
    input  logic [ntc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ntc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output ntc_pkg::t_flags                    o_flags,
    output logic signed [ntc_pkg::TEMP_W-1:0]  o_temperature_centi_c,
    output logic [ntc_pkg::STATUS_W-1:0]       o_status
);
    import ntc_pkg::*;

    // State and configuration
    logic [SAMPLE_W-1:0] r_ring [WINDOW];
    logic [SLOT_W-1:0]   r_slot;
    logic [SUM_W-1:0]    r_sum;
    logic [RES_W-1:0]    r_series;
    logic [RES_W-1:0]    r_nomr;
    logic [BETA_W-1:0]   r_beta;
    logic [T0_W-1:0]     r_t0;
    logic [MV_W-1:0]     r_ref;
    logic [MV_W-1:0]     r_fs_mv;
    logic [CODE_W-1:0]   r_fs_code;

    // Working registers
    logic [SAMPLE_W-1:0]       r_mean;
    logic [NUM_W-1:0]          r_num;
    logic [NUM_W-1:0]          r_limc;
    logic [CODE_W-1:0]         r_den;
    logic [NUM_W-1:0]          r_diff;
    logic [RN_W-1:0]           r_rn;
    logic [RLO_W-1:0]          r_rlo;
    logic [RHI_W-1:0]          r_rhi;
    logic signed [LQ_W-1:0]    r_lq;
    logic [TB_W-1:0]           r_tb;
    logic [B100_W-1:0]         r_b100;
    logic signed [TL_W-1:0]    r_tl;
    logic [NUMER_W-1:0]        r_numer;
    logic signed [TDEN_W-1:0]  r_tden;
    logic signed [TEMP_W-1:0]  r_temp;
    logic [STATUS_W-1:0]       r_status;

    logic [CODE_W-1:0]   w_code;
    logic [RES_W-1:0]    w_rnom;
    logic [BETA_W-1:0]   w_b;
    logic [MV_W-1:0]     w_lim;
    logic [MEAN_PW-1:0]  w_mean_prod;
    logic [NUM_W-1:0]    w_num_prod;
    logic [NUM_W-1:0]    w_limc;
    logic [NUM_W-1:0]    w_refden;
    logic [DEN100_W-1:0] w_den100;
    logic [RN0_W-1:0]    w_rn0;
    logic [RN1_W-1:0]    w_rn1;
    logic [RLO_W-1:0]    w_rlo;
    logic [RHI_W-1:0]    w_rhi;
    logic [TB_W-1:0]     w_tb;
    logic [B100_W-1:0]   w_b100;
    logic [TB100_W-1:0]  w_tb100;
    logic signed [TL_W-1:0]   w_tl;
    logic signed [TDEN_W-1:0] w_tden;
    logic [LN_ARG_W-1:0] w_ln_arg;
    logic                w_ln_done;
    logic signed [LQ_W-1:0] w_ln_res;
    logic [DIVD_W-1:0]   w_dividend;
    logic                w_div_done;
    logic [DIVD_W-1:0]   w_quot;
    logic [15:0]         w_tc;

    assign w_code = (r_fs_code == '0) ? CODE_W'(1) : r_fs_code;
    assign w_rnom = (r_nomr == '0) ? RES_W'(1) : r_nomr;
    assign w_b    = (r_beta == '0) ? BETA_W'(1) : r_beta;
    assign w_lim  = r_ref - MV_W'(10);

    assign w_mean_prod = MEAN_PW'(r_sum) * MEAN_PW'(MEAN_RECIP);
    assign w_num_prod  = NUM_W'(r_mean) * NUM_W'(r_fs_mv);
    assign w_limc      = NUM_W'(w_lim) * NUM_W'(w_code);
    assign w_refden    = NUM_W'(r_ref) * NUM_W'(r_den);
    assign w_den100    = DEN100_W'(r_den) * DEN100_W'(100);
    assign w_rn0       = RN0_W'(r_series) * RN0_W'(r_diff[12:0]);
    assign w_rn1       = RN1_W'(r_series) * RN1_W'(r_diff[NUM_W-1:13]);
    assign w_rlo       = RLO_W'(r_num) * RLO_W'(100);
    assign w_rhi       = RHI_W'(r_num) * RHI_W'(200000);
    assign w_tb        = TB_W'(r_t0) * TB_W'(w_b);
    assign w_b100      = B100_W'(w_b) * B100_W'(100);
    assign w_tb100     = TB100_W'(r_tb) * TB100_W'(100);
    assign w_tl        = TL_W'(signed'({1'b0, r_t0})) * TL_W'(r_lq);
    assign w_tden      = TDEN_W'(signed'({1'b0, r_b100, 16'd0})) + TDEN_W'(r_tl);
    // The denominator is known positive when the divider starts.
    assign w_dividend  = DIVD_W'(r_numer) + DIVD_W'(r_tden[TDEN_W-2:1]);
    assign w_tc        = w_quot[15:0] - CK_OFFSET;

    always_comb begin
        case (i_cmd.ln_sel)
            LN_SEL_RN: w_ln_arg = LN_ARG_W'(r_rn);
            LN_SEL_RD: w_ln_arg = LN_ARG_W'(r_num);
            default:   w_ln_arg = LN_ARG_W'(w_rnom);
        endcase
    end

    ntc_ln u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_LN_START),
        .i_arg   (w_ln_arg),
        .o_done  (w_ln_done),
        .o_res   (w_ln_res)
    );

    ntc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV_START),
        .i_dividend (w_dividend),
        .i_divisor  (r_tden[DIVS_W-1:0]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_ring[k] <= '0;
            end
            r_slot    <= '0;
            r_sum     <= '0;
            r_series  <= RST_SERIES;
            r_nomr    <= RST_NOMR;
            r_beta    <= RST_BETA;
            r_t0      <= RST_T0;
            r_ref     <= RST_REF;
            r_fs_mv   <= RST_FS_MV;
            r_fs_code <= RST_FS_CODE;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SERIES:    r_series  <= i_cfg_data[RES_W-1:0];
                    CFG_NOMINAL_R: r_nomr    <= i_cfg_data[RES_W-1:0];
                    CFG_BETA:      r_beta    <= i_cfg_data[BETA_W-1:0];
                    CFG_T0:        r_t0      <= i_cfg_data[T0_W-1:0];
                    CFG_REF:       r_ref     <= i_cfg_data[MV_W-1:0];
                    CFG_FS_MV:     r_fs_mv   <= i_cfg_data[MV_W-1:0];
                    CFG_FS_CODE:   r_fs_code <= i_cfg_data[CODE_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_LOAD) begin
                // Running sum: drop the oldest word, add the new one.
                r_ring[r_slot] <= i_adc_sample;
                r_sum  <= r_sum - SUM_W'(r_ring[r_slot]) + SUM_W'(i_adc_sample);
                r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_MEAN: r_mean <= w_mean_prod[MEAN_SHIFT +: SAMPLE_W];
            OP_VOLT: begin
                r_num  <= w_num_prod;
                r_limc <= w_limc;
                r_den  <= w_code;
            end
            OP_CLIP: begin
                // Voltage at or above the limit is held at reference minus 10 mV.
                if (r_num >= r_limc) begin
                    r_num <= NUM_W'(w_lim);
                    r_den <= CODE_W'(1);
                end
            end
            OP_DIFF: r_diff <= w_refden - r_num;
            OP_RN0:  r_rn   <= RN_W'(w_rn0);
            OP_RN1:  r_rn   <= r_rn + {w_rn1, 13'd0};
            OP_RCMP: begin
                r_rlo <= w_rlo;
                r_rhi <= w_rhi;
            end
            OP_LQ_UPD: begin
                if (i_cmd.ln_sel == LN_SEL_RN) begin
                    r_lq <= w_ln_res;
                end else begin
                    r_lq <= r_lq - w_ln_res;
                end
            end
            OP_TB: begin
                r_tb   <= w_tb;
                r_b100 <= w_b100;
            end
            OP_TL: begin
                r_tl    <= w_tl;
                r_numer <= {w_tb100, 16'd0};
            end
            OP_TDEN: r_tden <= w_tden;
            OP_EMIT: begin
                case (i_cmd.status)
                    ST_NORMAL: r_temp <= signed'(w_tc[TEMP_W-1:0]);
                    ST_BELOW:  r_temp <= signed'(TEMP_FLOOR_SUB);
                    ST_ABOVE:  r_temp <= signed'(TEMP_CEIL_SUB);
                    default:   r_temp <= signed'(TEMP_DEFAULT);
                endcase
                r_status <= i_cmd.status;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_flags.zero_mean = (r_mean == '0);
        o_flags.lim_low   = (r_ref < MV_W'(110));
        o_flags.volt_low  = (r_num < NUM_W'(w_den100));
        o_flags.r_out     = (r_rn < RN_W'(r_rlo)) || (r_rn > RN_W'(r_rhi));
        o_flags.ln_done   = w_ln_done;
        o_flags.tden_zero = (r_tden == '0);
        o_flags.tden_neg  = r_tden[TDEN_W-1];
        o_flags.div_done  = w_div_done;
        o_flags.q_low     = (w_quot < DIVD_W'(Q_FLOOR));
        o_flags.q_high    = (w_quot > DIVD_W'(Q_CEIL));
    end

    assign o_temperature_centi_c = r_temp;
    assign o_status              = r_status;

endmodule

[design/ntc_ctrl.sv]
// ----------------------------------------------------------------------------
// ntc_ctrl: sequencer of the NTC thermistor temperature block
// Steps the datapath through mean, voltage, resistance, logarithms and the
// beta equation, picks the status and drives both handshakes.
// ----------------------------------------------------------------------------
module ntc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  ntc_pkg::t_flags  i_flags,
    output ntc_pkg::t_cmd    o_cmd
);
    import ntc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_MEAN, S_VOLT, S_CLIP, S_VCHK, S_RN0, S_RN1, S_RCMP, S_RCHK,
        S_LNS, S_LNW, S_TB, S_TL, S_TDEN, S_TCHK, S_DIVW, S_QCHK, S_EMIT
    } t_state;

    t_state  r_state, n_state;
    t_status r_st, n_st;
    t_ln_sel r_lnsel, n_lnsel;
    logic    r_valid, n_valid;
    t_cmd    w_cmd;

    always_comb begin
        n_state      = r_state;
        n_st         = r_st;
        n_lnsel      = r_lnsel;
        n_valid      = r_valid && i_out_stall;
        w_cmd.op     = OP_NONE;
        w_cmd.status = r_st;
        w_cmd.ln_sel = r_lnsel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.op = OP_LOAD;
                    n_state  = S_MEAN;
                end
            end
            S_MEAN: begin
                w_cmd.op = OP_MEAN;
                n_state  = S_VOLT;
            end
            S_VOLT: begin
                if (i_flags.zero_mean) begin
                    n_st    = ST_ZERO_MEAN;
                    n_state = S_EMIT;
                end else if (i_flags.lim_low) begin
                    n_st    = ST_VOLT_LOW;
                    n_state = S_EMIT;
                end else begin
                    w_cmd.op = OP_VOLT;
                    n_state  = S_CLIP;
                end
            end
            S_CLIP: begin
                w_cmd.op = OP_CLIP;
                n_state  = S_VCHK;
            end
            S_VCHK: begin
                if (i_flags.volt_low) begin
                    n_st    = ST_VOLT_LOW;
                    n_state = S_EMIT;
                end else begin
                    w_cmd.op = OP_DIFF;
                    n_state  = S_RN0;
                end
            end
            S_RN0: begin
                w_cmd.op = OP_RN0;
                n_state  = S_RN1;
            end
            S_RN1: begin
                w_cmd.op = OP_RN1;
                n_state  = S_RCMP;
            end
            S_RCMP: begin
                w_cmd.op = OP_RCMP;
                n_state  = S_RCHK;
            end
            S_RCHK: begin
                if (i_flags.r_out) begin
                    n_st    = ST_R_RANGE;
                    n_state = S_EMIT;
                end else begin
                    n_lnsel = LN_SEL_RN;
                    n_state = S_LNS;
                end
            end
            S_LNS: begin
                w_cmd.op = OP_LN_START;
                n_state  = S_LNW;
            end
            S_LNW: begin
                // Three logs in turn: resistance numerator, its divisor, nominal resistance.
                if (i_flags.ln_done) begin
                    w_cmd.op = OP_LQ_UPD;
                    case (r_lnsel)
                        LN_SEL_RN: begin
                            n_lnsel = LN_SEL_RD;
                            n_state = S_LNS;
                        end
                        LN_SEL_RD: begin
                            n_lnsel = LN_SEL_NOM;
                            n_state = S_LNS;
                        end
                        default: n_state = S_TB;
                    endcase
                end
            end
            S_TB: begin
                w_cmd.op = OP_TB;
                n_state  = S_TL;
            end
            S_TL: begin
                w_cmd.op = OP_TL;
                n_state  = S_TDEN;
            end
            S_TDEN: begin
                w_cmd.op = OP_TDEN;
                n_state  = S_TCHK;
            end
            S_TCHK: begin
                if (i_flags.tden_zero) begin
                    n_st    = ST_ABOVE;
                    n_state = S_EMIT;
                end else if (i_flags.tden_neg) begin
                    n_st    = ST_BELOW;
                    n_state = S_EMIT;
                end else begin
                    w_cmd.op = OP_DIV_START;
                    n_state  = S_DIVW;
                end
            end
            S_DIVW: begin
                if (i_flags.div_done) begin
                    n_state = S_QCHK;
                end
            end
            S_QCHK: begin
                if (i_flags.q_low) begin
                    n_st = ST_BELOW;
                end else if (i_flags.q_high) begin
                    n_st = ST_ABOVE;
                end else begin
                    n_st = ST_NORMAL;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // The result register is free when empty or being taken now.
                if (!r_valid || !i_out_stall) begin
                    w_cmd.op = OP_EMIT;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_NORMAL;
            r_lnsel <= LN_SEL_RN;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
            r_lnsel <= n_lnsel;
            r_valid <= n_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_valid;
    assign o_cmd       = w_cmd;

endmodule

[design/ntc_thermistor_temperature.sv]
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature: NTC thermistor temperature from ADC samples
// Ten-sample moving mean, divider resistance and beta equation, giving the
// temperature in hundredths of a degree C with a status code.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  input    in         i_in_valid / o_in_stall   i_adc_sample
//  output   out        o_out_valid / i_out_stall o_temperature_centi_c, o_status
//  config   in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  A word that runs the whole equation passes from acceptance to the result
//  register through the three logarithms, whose time varies with normalization
//  length, and the wait on the 54-step divider. Words that end early on a range
//  check skip the rest of the equation and go to the result register.
//  Reset, sampled on the clock, clears the sample ring and loads the default configuration.
//  The input stalls until the result is registered; the next word is taken
//  while the previous result still waits on the output.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ntc_pkg::SAMPLE_W-1:0]       i_adc_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [ntc_pkg::TEMP_W-1:0]  o_temperature_centi_c,
    output logic [ntc_pkg::STATUS_W-1:0]       o_status,
    input  logic                               i_cfg_we,
    input  logic [ntc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ntc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ntc_pkg::*;

    t_cmd   w_cmd;
    t_flags w_flags;

    ntc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_flags     (w_flags),
        .o_cmd       (w_cmd)
    );

    ntc_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .i_adc_sample          (i_adc_sample),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .o_flags               (w_flags),
        .o_temperature_centi_c (o_temperature_centi_c),
        .o_status              (o_status)
    );

endmodule

[design/ntc_chk.sv]
// ----------------------------------------------------------------------------
// ntc_chk: port checker of the NTC thermistor temperature block
// Watches the top-level ports and is bound to the top level below.
// ----------------------------------------------------------------------------
module ntc_chk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_stall,
    input  logic                               o_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [ntc_pkg::TEMP_W-1:0]  o_temperature_centi_c,
    input  logic [ntc_pkg::STATUS_W-1:0]       o_status
);
    import ntc_pkg::*;

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // One word at a time: an accepted word stalls the input next cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before the result was formed");

    // A normal result lies within the floor and the ceiling.
    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_NORMAL) |->
            (o_temperature_centi_c >= -14'sd1000) && (o_temperature_centi_c <= 14'sd8000))
        else $error("normal temperature out of range");

    // Substitute temperatures match their status codes.
    a_substitute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_ZERO_MEAN || o_status == ST_VOLT_LOW ||
                        o_status == ST_R_RANGE) |->
            (o_temperature_centi_c == signed'(TEMP_DEFAULT)))
        else $error("default temperature missing for input fault");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_BELOW || o_status == ST_ABOVE) |->
            (o_temperature_centi_c == signed'(TEMP_FLOOR_SUB) && o_status == ST_BELOW) ||
            (o_temperature_centi_c == signed'(TEMP_CEIL_SUB) && o_status == ST_ABOVE))
        else $error("substitute temperature does not match its status");

endmodule

bind ntc_thermistor_temperature ntc_chk u_ntc_chk (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_in_valid            (i_in_valid),
    .o_in_stall            (o_in_stall),
    .o_out_valid           (o_out_valid),
    .i_out_stall           (i_out_stall),
    .o_temperature_centi_c (o_temperature_centi_c),
    .o_status              (o_status)
);
